// ===== src/chmc_pkg.sv =====
package chmc_pkg;

    // most vertices returned for one set
    localparam int RESULT_LIMIT = 32;

    typedef struct packed {
        logic load_wr;      // store an incoming point
        logic sort_init;
        logic sort_latch_v; // take the key being inserted
        logic sort_rd_prev; // read the entry below the gap
        logic sort_shift;   // move that entry up
        logic sort_place;   // drop the key into the gap
        logic hull_init;
        logic h_load;
        logic h_mul;
        logic h_pop;
        logic h_popw;
        logic h_push;
        logic h_next;
        logic out_init;
        logic out_rd;
        logic out_load;
        logic out_step;
    } cmd_t;

    typedef struct packed {
        logic i_ge_n;
        logic j_zero;
        logic before_hit;
        logic pop_hit;
        logic hull_end;
        logic out_last_q;
    } sts_t;

endpackage

// ===== src/convex_hull_monotone_chain_unit.sv =====
// channel  ports      tdata (low bit up)   tlast       tuser
// in       s_axis_*   point_x, point_y     is_last     -
// out      m_axis_*   hull_x, hull_y       hull_last   dropped_points
//
// Loading takes one word per cycle. After the last point an insertion sort
// runs on the point RAM, then the stack walk, which tests each point with
// the registered cross-product multipliers. Each vertex is read back from
// the stack RAM before it is offered.
// Synchronous active-low reset returns the block to loading with an empty
// set. A stalled m_tready holds the current vertex; no input is taken
// until the whole hull is delivered.
module convex_hull_monotone_chain_unit #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,  // point_x, point_y
    input  logic                                  s_tlast,  // is_last
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,  // hull_x, hull_y
    output logic                                  m_tlast,  // hull_last
    output logic                                  m_tuser   // dropped_points
);

    localparam int DW = ((2 * COORD_BITS + 7) / 8) * 8;

    chmc_pkg::cmd_t cmd;
    chmc_pkg::sts_t sts;
    logic [COORD_BITS-1:0] hx, hy;
    logic in_fire;

    assign in_fire = s_tvalid && s_tready;

    chmc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    chmc_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_x     (s_tdata[COORD_BITS-1:0]),
        .in_y     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .out_x    (hx),
        .out_y    (hy),
        .out_last (m_tlast),
        .out_drop (m_tuser)
    );

    assign m_tdata = DW'({hy, hx});

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input open while a vertex is pending");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after last point");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("not back to loading after final vertex");

endmodule

// ===== src/chmc_ram.sv =====
module chmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/chmc_ctrl.sv =====
module chmc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic          in_last,
    input  logic          out_ready,
    input  chmc_pkg::sts_t sts,
    output chmc_pkg::cmd_t cmd,
    output logic          in_ready,
    output logic          out_valid
);

    typedef enum logic [13:0] {
        ST_LOAD       = 14'b00000000000001,
        ST_SORT_START = 14'b00000000000010,
        ST_SORT_V     = 14'b00000000000100,
        ST_SORT_RD    = 14'b00000000001000,
        ST_SORT_CMP   = 14'b00000000010000,
        ST_H_FETCH    = 14'b00000000100000,
        ST_H_LOAD     = 14'b00000001000000,
        ST_H_MUL      = 14'b00000010000000,
        ST_H_EVAL     = 14'b00000100000000,
        ST_H_POPW     = 14'b00001000000000,
        ST_H_NEXT     = 14'b00010000000000,
        ST_O_RD       = 14'b00100000000000,
        ST_O_WAIT     = 14'b01000000000000,
        ST_O_HOLD     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    cmd.load_wr = 1'b1;
                    if (in_last) begin
                        cmd.sort_init = 1'b1;
                        state_next    = ST_SORT_START;
                    end
                end
            end
            ST_SORT_START: begin
                if (sts.i_ge_n) begin
                    cmd.hull_init = 1'b1;
                    state_next    = ST_H_FETCH;
                end else begin
                    state_next = ST_SORT_V;
                end
            end
            ST_SORT_V: begin
                cmd.sort_latch_v = 1'b1;
                state_next       = ST_SORT_RD;
            end
            ST_SORT_RD: begin
                if (sts.j_zero) begin
                    cmd.sort_place = 1'b1;
                    state_next     = ST_SORT_START;
                end else begin
                    cmd.sort_rd_prev = 1'b1;
                    state_next       = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP: begin
                if (sts.before_hit) begin
                    cmd.sort_shift = 1'b1;
                    state_next     = ST_SORT_RD;
                end else begin
                    cmd.sort_place = 1'b1;
                    state_next     = ST_SORT_START;
                end
            end
            ST_H_FETCH: begin
                state_next = ST_H_LOAD;
            end
            ST_H_LOAD: begin
                cmd.h_load = 1'b1;
                state_next = ST_H_MUL;
            end
            ST_H_MUL: begin
                cmd.h_mul  = 1'b1;
                state_next = ST_H_EVAL;
            end
            ST_H_EVAL: begin
                if (sts.pop_hit) begin
                    cmd.h_pop  = 1'b1;
                    state_next = ST_H_POPW;
                end else begin
                    cmd.h_push = 1'b1;
                    state_next = ST_H_NEXT;
                end
            end
            ST_H_POPW: begin
                cmd.h_popw = 1'b1;
                state_next = ST_H_MUL;
            end
            ST_H_NEXT: begin
                if (sts.hull_end) begin
                    cmd.out_init = 1'b1;
                    state_next   = ST_O_RD;
                end else begin
                    cmd.h_next = 1'b1;
                    state_next = ST_H_FETCH;
                end
            end
            ST_O_RD: begin
                cmd.out_rd = 1'b1;
                state_next = ST_O_WAIT;
            end
            ST_O_WAIT: begin
                cmd.out_load = 1'b1;
                state_next   = ST_O_HOLD;
            end
            ST_O_HOLD: begin
                if (out_ready) begin
                    cmd.out_step = 1'b1;
                    state_next   = sts.out_last_q ? ST_LOAD : ST_O_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_O_HOLD);

endmodule

// ===== src/chmc_dp.sv =====
module chmc_dp #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  chmc_pkg::cmd_t        cmd,
    output chmc_pkg::sts_t        sts,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS-1:0] out_y,
    output logic                  out_last,
    output logic                  out_drop
);

    localparam int CB = COORD_BITS;
    localparam int PW = 2 * CB;
    localparam int SA = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SD = 2 * MAX_POINTS;
    localparam int KA = $clog2(SD);
    localparam int KW = $clog2(SD + 1);
    localparam int MW = 2 * CB + 2;

    logic [CW-1:0] count_reg, i_reg, j_reg;
    logic          ovf_reg, lower_reg;
    logic [PW-1:0] v_reg, p_reg, top1_reg, top2_reg, out_reg;
    logic [KW-1:0] k_reg, t_reg, o_reg;
    logic signed [MW-1:0] prod_a_reg, prod_b_reg;
    logic          out_last_reg, out_drop_reg;

    logic          st_we;
    logic [SA-1:0] st_waddr, st_raddr;
    logic [PW-1:0] st_wdata, st_rdata, stk_rdata;
    logic [KA-1:0] stk_raddr;
    logic [CW-1:0] jm1;
    logic [KW-1:0] km3, cnt_raw, cnt, lim;
    logic          store_full;

    assign store_full = (count_reg >= CW'(MAX_POINTS));
    assign jm1        = j_reg - 1'b1;
    assign km3        = k_reg - KW'(3);

    always_comb begin
        st_we    = (cmd.load_wr && !store_full) || cmd.sort_shift || cmd.sort_place;
        st_waddr = cmd.load_wr ? count_reg[SA-1:0] : j_reg[SA-1:0];
        if (cmd.load_wr) begin
            st_wdata = {in_y, in_x};
        end else if (cmd.sort_shift) begin
            st_wdata = st_rdata;
        end else begin
            st_wdata = v_reg;
        end
        st_raddr  = cmd.sort_rd_prev ? jm1[SA-1:0] : i_reg[SA-1:0];
        stk_raddr = cmd.out_rd ? o_reg[KA-1:0] : km3[KA-1:0];
    end

    chmc_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    chmc_ram #(.WIDTH(PW), .DEPTH(SD)) u_stack (
        .aclk  (aclk),
        .we    (cmd.h_push),
        .waddr (k_reg[KA-1:0]),
        .wdata (p_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // lexicographic compare of the key against the entry below the gap
    logic signed [CB-1:0] vx, vy, dx, dy;
    assign vx = v_reg[CB-1:0];
    assign vy = v_reg[PW-1:CB];
    assign dx = st_rdata[CB-1:0];
    assign dy = st_rdata[PW-1:CB];

    // turn(top2, top1, p) = a - b
    logic signed [CB:0] ax, ay, bx, by;
    assign ax = $signed({top1_reg[CB-1], top1_reg[CB-1:0]})
              - $signed({top2_reg[CB-1], top2_reg[CB-1:0]});
    assign ay = $signed({top1_reg[PW-1], top1_reg[PW-1:CB]})
              - $signed({top2_reg[PW-1], top2_reg[PW-1:CB]});
    assign bx = $signed({p_reg[CB-1], p_reg[CB-1:0]})
              - $signed({top2_reg[CB-1], top2_reg[CB-1:0]});
    assign by = $signed({p_reg[PW-1], p_reg[PW-1:CB]})
              - $signed({top2_reg[PW-1], top2_reg[PW-1:CB]});

    always_comb begin
        cnt_raw = (count_reg == CW'(1)) ? KW'(1) : (k_reg - 1'b1);
        if (32'(cnt_raw) > chmc_pkg::RESULT_LIMIT) begin
            cnt = KW'(chmc_pkg::RESULT_LIMIT);
        end else begin
            cnt = cnt_raw;
        end
        lim = lower_reg ? KW'(2) : t_reg;
    end

    always_comb begin
        sts.i_ge_n     = (i_reg >= count_reg);
        sts.j_zero     = (j_reg == '0);
        sts.before_hit = (vx < dx) || ((vx == dx) && (vy < dy));
        sts.pop_hit    = (k_reg >= lim) && (prod_a_reg <= prod_b_reg);
        sts.hull_end   = lower_reg ? ((CW'(i_reg + 1'b1) == count_reg) &&
                                      (count_reg < CW'(2)))
                                   : (i_reg == '0);
        sts.out_last_q = out_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cmd.load_wr) begin
                if (store_full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.out_step && out_last_reg) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sort_init) begin
            i_reg <= CW'(1);
        end
        if (cmd.sort_latch_v) begin
            v_reg <= st_rdata;
            j_reg <= i_reg;
        end
        if (cmd.sort_shift) begin
            j_reg <= jm1;
        end
        if (cmd.sort_place) begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.hull_init) begin
            i_reg     <= '0;
            k_reg     <= '0;
            lower_reg <= 1'b1;
        end
        if (cmd.h_load) begin
            p_reg <= st_rdata;
        end
        if (cmd.h_mul) begin
            prod_a_reg <= ax * by;
            prod_b_reg <= ay * bx;
        end
        if (cmd.h_pop) begin
            k_reg    <= k_reg - 1'b1;
            top1_reg <= top2_reg;
        end
        if (cmd.h_popw) begin
            top2_reg <= stk_rdata;
        end
        if (cmd.h_push) begin
            k_reg    <= k_reg + 1'b1;
            top2_reg <= top1_reg;
            top1_reg <= p_reg;
        end
        if (cmd.h_next) begin
            if (lower_reg) begin
                if (CW'(i_reg + 1'b1) == count_reg) begin
                    lower_reg <= 1'b0;
                    t_reg     <= k_reg + 1'b1;
                    i_reg     <= count_reg - CW'(2);
                end else begin
                    i_reg <= i_reg + 1'b1;
                end
            end else begin
                i_reg <= i_reg - 1'b1;
            end
        end
        if (cmd.out_init) begin
            o_reg <= '0;
        end
        if (cmd.out_load) begin
            out_reg      <= stk_rdata;
            out_last_reg <= (KW'(o_reg + 1'b1) == cnt);
            out_drop_reg <= ovf_reg;
        end
        if (cmd.out_step) begin
            o_reg <= o_reg + 1'b1;
        end
    end

    assign out_x    = out_reg[CB-1:0];
    assign out_y    = out_reg[PW-1:CB];
    assign out_last = out_last_reg;
    assign out_drop = out_drop_reg;

endmodule
